// ----- hdl/tjq_pkg.sv -----
// Package with types, codes and defaults shared by the tagged job queue.
`timescale 1ns / 1ps
`default_nettype none
package tjq_pkg;

  localparam int unsigned DefaultDepth = 16;

  localparam int unsigned FuncWidth   = 2;
  localparam int unsigned IdWidth     = 8;
  localparam int unsigned JobWidth    = 16;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned CountWidth  = 5;

  localparam logic [JobWidth-1:0] FirstJob = 16'd1;
  localparam logic [JobWidth-1:0] LastJob  = 16'hFFFF;

  typedef enum logic [FuncWidth-1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_CANCEL = 2'd2
  } tjq_func_e;

  typedef enum logic [StatusWidth-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } tjq_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_POP_WAIT,
    ST_SCAN,
    ST_FINISH
  } tjq_state_e;

  typedef struct packed {
    logic [JobWidth-1:0] job;
    logic [IdWidth-1:0]  user;
    logic [IdWidth-1:0]  prog;
  } tjq_entry_t;

  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic [JobWidth-1:0]    out_job;
    logic [IdWidth-1:0]     out_user;
    logic [IdWidth-1:0]     out_program;
    logic [CountWidth-1:0]  removed_count;
    logic [CountWidth-1:0]  occupancy;
  } tjq_result_t;

endpackage
`default_nettype wire

// ----- hdl/tjq_req_if.sv -----
// Request channel interface of the tagged job queue.
`timescale 1ns / 1ps
`default_nettype none
interface tjq_req_if;
  logic                           valid;
  logic                           ready;
  logic [tjq_pkg::FuncWidth-1:0]  func;
  logic [tjq_pkg::IdWidth-1:0]    user_id;
  logic [tjq_pkg::IdWidth-1:0]    program_id;
  logic [tjq_pkg::JobWidth-1:0]   cancel_job;

  modport source (output valid, func, user_id, program_id, cancel_job, input ready);
  modport sink   (input valid, func, user_id, program_id, cancel_job, output ready);
endinterface
`default_nettype wire

// ----- hdl/tjq_rsp_if.sv -----
// Response channel interface of the tagged job queue.
`timescale 1ns / 1ps
`default_nettype none
interface tjq_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [tjq_pkg::StatusWidth-1:0] status;
  logic [tjq_pkg::JobWidth-1:0]    out_job;
  logic [tjq_pkg::IdWidth-1:0]     out_user;
  logic [tjq_pkg::IdWidth-1:0]     out_program;
  logic [tjq_pkg::CountWidth-1:0]  removed_count;
  logic [tjq_pkg::CountWidth-1:0]  occupancy;

  modport source (output valid, status, out_job, out_user, out_program, removed_count,
                  occupancy, input ready);
  modport sink   (input valid, status, out_job, out_user, out_program, removed_count,
                  occupancy, output ready);
endinterface
`default_nettype wire

// ----- hdl/tjq_store.sv -----
// Job entry memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module tjq_store #(
  parameter int unsigned DEPTH = tjq_pkg::DefaultDepth
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire tjq_pkg::tjq_entry_t      wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output tjq_pkg::tjq_entry_t           rdata_o
);

  tjq_pkg::tjq_entry_t mem_q [DEPTH];
  tjq_pkg::tjq_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hdl/tagged_job_queue_with_flush.sv -----
// Top level of the tagged job queue: sequencer, queue pointers and output register.
// An accepted request goes from DECODE to FINISH, through POP_WAIT for a pop and through SCAN
// for a cancel on a non-empty queue; in SCAN one comparator walks the store one entry per
// cycle from the head until the match, or over the whole occupancy when absent. FINISH
// loads the output register and raises valid once it is free. A new request is taken only
// in IDLE, so a waiting response that stalls FINISH holds the block off. Reset clears the
// pointers, the count and sets the job counter to one; only written store entries are used.
`timescale 1ns / 1ps
`default_nettype none
module tagged_job_queue_with_flush #(
  parameter int unsigned DEPTH = tjq_pkg::DefaultDepth
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tjq_req_if.sink    req_i,
  tjq_rsp_if.source  rsp_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tjq_pkg::tjq_state_e state_q, state_d;

  logic [tjq_pkg::FuncWidth-1:0] func_q;
  logic [tjq_pkg::IdWidth-1:0]   user_q;
  logic [tjq_pkg::IdWidth-1:0]   prog_q;
  logic [tjq_pkg::JobWidth-1:0]  target_q;

  logic [IW-1:0]                 head_q, head_d;
  logic [CW-1:0]                 count_q, count_d;
  logic [tjq_pkg::JobWidth-1:0]  next_job_q, next_job_d;
  logic [CW-1:0]                 idx_q, idx_d;

  tjq_pkg::tjq_result_t          res_q, res_d;
  tjq_pkg::tjq_result_t          out_q;
  logic                          out_valid_q, out_valid_d;

  logic [CW-1:0]                 offset_s;
  logic [CW:0]                   sum_s;
  logic [IW-1:0]                 slot_s;

  logic                          we_s;
  logic [IW-1:0]                 raddr_s;
  tjq_pkg::tjq_entry_t           wdata_s;
  tjq_pkg::tjq_entry_t           rdata_s;

  logic                          accept_s;
  logic                          out_free_s;

  assign accept_s   = req_i.valid && req_i.ready;
  assign out_free_s = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == tjq_pkg::ST_IDLE);

  assign offset_s = (state_q == tjq_pkg::ST_SCAN) ? idx_q + CW'(1) : count_q;
  assign sum_s    = {1'b0, CW'(head_q)} + {1'b0, offset_s};
  assign slot_s   = (sum_s >= (CW + 1)'(DEPTH)) ? IW'(sum_s - (CW + 1)'(DEPTH)) : IW'(sum_s);
  assign raddr_s  = (state_q == tjq_pkg::ST_SCAN) ? slot_s : head_q;

  assign wdata_s.job  = next_job_q;
  assign wdata_s.user = user_q;
  assign wdata_s.prog = prog_q;

  tjq_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we_s),
    .waddr_i (slot_s),
    .wdata_i (wdata_s),
    .raddr_i (raddr_s),
    .rdata_o (rdata_s)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    next_job_d  = next_job_q;
    idx_d       = idx_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    we_s        = 1'b0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      tjq_pkg::ST_IDLE: begin
        if (accept_s) begin
          state_d = tjq_pkg::ST_DECODE;
        end
      end
      tjq_pkg::ST_DECODE: begin
        res_d        = '0;
        res_d.status = tjq_pkg::STATUS_OK;
        state_d      = tjq_pkg::ST_FINISH;
        idx_d        = '0;
        case (func_q)
          tjq_pkg::FUNC_PUSH: begin
            if (count_q == CW'(DEPTH)) begin
              res_d.status = tjq_pkg::STATUS_FULL;
            end else begin
              we_s          = 1'b1;
              res_d.out_job = next_job_q;
              count_d       = count_q + CW'(1);
              next_job_d    = (next_job_q == tjq_pkg::LastJob) ? tjq_pkg::FirstJob
                                                               : next_job_q + 16'd1;
            end
          end
          tjq_pkg::FUNC_POP: begin
            if (count_q == '0) begin
              res_d.status = tjq_pkg::STATUS_EMPTY;
            end else begin
              state_d = tjq_pkg::ST_POP_WAIT;
            end
          end
          tjq_pkg::FUNC_CANCEL: begin
            if (count_q == '0) begin
              res_d.status = tjq_pkg::STATUS_EMPTY;
            end else begin
              state_d = tjq_pkg::ST_SCAN;
            end
          end
          default: begin
          end
        endcase
        res_d.occupancy = tjq_pkg::CountWidth'(count_d);
      end
      tjq_pkg::ST_POP_WAIT: begin
        res_d.out_job       = rdata_s.job;
        res_d.out_user      = rdata_s.user;
        res_d.out_program   = rdata_s.prog;
        res_d.removed_count = tjq_pkg::CountWidth'(1);
        head_d              = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + IW'(1);
        count_d             = count_q - CW'(1);
        res_d.occupancy     = tjq_pkg::CountWidth'(count_d);
        state_d             = tjq_pkg::ST_FINISH;
      end
      tjq_pkg::ST_SCAN: begin
        if (rdata_s.job == target_q) begin
          res_d.out_job       = target_q;
          res_d.removed_count = tjq_pkg::CountWidth'(count_q - idx_q);
          count_d             = idx_q;
          res_d.occupancy     = tjq_pkg::CountWidth'(idx_q);
          state_d             = tjq_pkg::ST_FINISH;
        end else if (idx_q + CW'(1) == count_q) begin
          res_d.status = tjq_pkg::STATUS_NOT_FOUND;
          state_d      = tjq_pkg::ST_FINISH;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      tjq_pkg::ST_FINISH: begin
        if (out_free_s) begin
          out_valid_d = 1'b1;
          state_d     = tjq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tjq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tjq_pkg::ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      next_job_q  <= tjq_pkg::FirstJob;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      next_job_q  <= next_job_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_s) begin
      func_q   <= req_i.func;
      user_q   <= req_i.user_id;
      prog_q   <= req_i.program_id;
      target_q <= req_i.cancel_job;
    end
    res_q <= res_d;
    if (state_q == tjq_pkg::ST_FINISH && out_free_s) begin
      out_q <= res_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_q.status;
  assign rsp_o.out_job       = out_q.out_job;
  assign rsp_o.out_user      = out_q.out_user;
  assign rsp_o.out_program   = out_q.out_program;
  assign rsp_o.removed_count = out_q.removed_count;
  assign rsp_o.occupancy     = out_q.occupancy;

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for the tagged job queue: a directed table, a long response stall and random traffic.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned Depth         = tjq_pkg::DefaultDepth;
  localparam int unsigned ClkPeriod     = 12;
  localparam int unsigned ResetCycles   = 5;
  localparam int unsigned HoldCycles    = 150;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 30;
  localparam logic [tjq_pkg::FuncWidth-1:0] FuncIgnored = 2'd3;

  typedef struct packed {
    logic [tjq_pkg::FuncWidth-1:0] func;
    logic [tjq_pkg::IdWidth-1:0]   user_id;
    logic [tjq_pkg::IdWidth-1:0]   program_id;
    logic [tjq_pkg::JobWidth-1:0]  cancel_job;
  } job_request_t;

  typedef struct {
    job_request_t         req;
    bit                   typed;
    tjq_pkg::tjq_result_t result;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;

  tjq_req_if req_if ();
  tjq_rsp_if rsp_if ();

  tagged_job_queue_with_flush #(
    .DEPTH(Depth)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  logic [tjq_pkg::JobWidth-1:0] jobs_q     [Depth];
  logic [tjq_pkg::IdWidth-1:0]  users_q    [Depth];
  logic [tjq_pkg::IdWidth-1:0]  programs_q [Depth];
  int unsigned                  head_slot;
  int unsigned                  held_jobs;
  logic [tjq_pkg::JobWidth-1:0] next_job_nr;

  tjq_pkg::tjq_result_t awaited_results[$];
  directed_row_t        directed_rows[$];
  tjq_pkg::tjq_result_t seen_result;
  tjq_pkg::tjq_result_t due_result;

  bit          steady_flow;
  bit          hold_request;
  int unsigned mismatch_count;
  int unsigned responses_checked;
  int unsigned idle_cycles;
  int unsigned func_tally[4];
  int unsigned full_rejects;
  int unsigned multi_cancels;
  int unsigned counter_wraps;

  function automatic tjq_pkg::tjq_result_t predict_queue_result(job_request_t r);
    tjq_pkg::tjq_result_t res;
    int unsigned slot;
    int unsigned hit_pos;
    bit hit;
    res = '0;
    hit = 1'b0;
    hit_pos = 0;
    case (r.func)
      tjq_pkg::FUNC_PUSH: begin
        if (held_jobs == Depth) begin
          res.status = tjq_pkg::STATUS_FULL;
        end else begin
          slot = (head_slot + held_jobs) % Depth;
          jobs_q[slot] = next_job_nr;
          users_q[slot] = r.user_id;
          programs_q[slot] = r.program_id;
          res.out_job = next_job_nr;
          held_jobs++;
          if (next_job_nr == tjq_pkg::LastJob) begin
            next_job_nr = tjq_pkg::FirstJob;
            counter_wraps++;
          end else begin
            next_job_nr = next_job_nr + 1'b1;
          end
        end
      end
      tjq_pkg::FUNC_POP: begin
        if (held_jobs == 0) begin
          res.status = tjq_pkg::STATUS_EMPTY;
        end else begin
          res.out_job = jobs_q[head_slot];
          res.out_user = users_q[head_slot];
          res.out_program = programs_q[head_slot];
          res.removed_count = tjq_pkg::CountWidth'(1);
          head_slot = (head_slot + 1) % Depth;
          held_jobs--;
        end
      end
      tjq_pkg::FUNC_CANCEL: begin
        if (held_jobs == 0) begin
          res.status = tjq_pkg::STATUS_EMPTY;
        end else begin
          for (int unsigned i = 0; i < held_jobs; i++) begin
            if (!hit && jobs_q[(head_slot + i) % Depth] == r.cancel_job) begin
              hit = 1'b1;
              hit_pos = i;
            end
          end
          if (hit) begin
            res.out_job = r.cancel_job;
            res.removed_count = tjq_pkg::CountWidth'(held_jobs - hit_pos);
            held_jobs = hit_pos;
          end else begin
            res.status = tjq_pkg::STATUS_NOT_FOUND;
          end
        end
      end
      default: ;
    endcase
    res.occupancy = tjq_pkg::CountWidth'(held_jobs);
    return res;
  endfunction

  function automatic void add_row(logic [tjq_pkg::FuncWidth-1:0] func,
                                  logic [tjq_pkg::IdWidth-1:0] user,
                                  logic [tjq_pkg::IdWidth-1:0] prog,
                                  logic [tjq_pkg::JobWidth-1:0] cancel,
                                  bit typed = 1'b0, tjq_pkg::tjq_result_t expected = '0);
    directed_row_t row;
    row.req = {func, user, prog, cancel};
    row.typed = typed;
    row.result = expected;
    directed_rows.push_back(row);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(99);
    if (steady_flow || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned pick_stall();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic job_request_t random_request(int unsigned push_weight);
    job_request_t r;
    int unsigned pick;
    r.user_id = tjq_pkg::IdWidth'($urandom);
    r.program_id = tjq_pkg::IdWidth'($urandom);
    r.cancel_job = tjq_pkg::JobWidth'($urandom);
    pick = $urandom_range(99);
    if (pick < 4) begin
      r.func = FuncIgnored;
    end else begin
      pick = $urandom_range(99);
      if (pick < push_weight) r.func = tjq_pkg::FUNC_PUSH;
      else if (pick < (push_weight + 100) / 2) r.func = tjq_pkg::FUNC_POP;
      else r.func = tjq_pkg::FUNC_CANCEL;
    end
    if (r.func == tjq_pkg::FUNC_CANCEL) begin
      pick = $urandom_range(99);
      if (held_jobs != 0 && pick < 75) begin
        r.cancel_job = jobs_q[(head_slot + $urandom_range(held_jobs - 1)) % Depth];
      end else if (pick < 85) begin
        r.cancel_job = '0;
      end else if (pick < 92) begin
        r.cancel_job = next_job_nr;
      end
    end
    return r;
  endfunction

  // Returns at the rising edge that takes the transaction, with valid still high.
  task automatic send_request(job_request_t r, bit typed = 1'b0,
                              tjq_pkg::tjq_result_t expected = '0);
    tjq_pkg::tjq_result_t predicted;
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.func       <= r.func;
    req_if.user_id    <= r.user_id;
    req_if.program_id <= r.program_id;
    req_if.cancel_job <= r.cancel_job;
    @(negedge clk);
    while (!req_if.ready) @(negedge clk);
    predicted = predict_queue_result(r);
    awaited_results.push_back(typed ? expected : predicted);
    func_tally[r.func]++;
    if (predicted.status == tjq_pkg::STATUS_FULL) full_rejects++;
    if (r.func == tjq_pkg::FUNC_CANCEL && predicted.removed_count > 1) multi_cancels++;
    @(posedge clk);
  endtask

  task automatic random_traffic(int unsigned count);
    int unsigned push_weight;
    push_weight = 50;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        push_weight = $urandom_range(25, 85);
        steady_flow = ($urandom_range(3) == 0);
      end
      send_request(random_request(push_weight));
    end
    steady_flow = 1'b0;
  endtask

  function automatic void check_field(string name, logic [tjq_pkg::JobWidth-1:0] want,
                                      logic [tjq_pkg::JobWidth-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(negedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      seen_result = {rsp_if.status, rsp_if.out_job, rsp_if.out_user, rsp_if.out_program,
                     rsp_if.removed_count, rsp_if.occupancy};
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected response, expected none, got %0h", $time, seen_result);
        mismatch_count++;
      end else begin
        due_result = awaited_results.pop_front();
        check_field("status", due_result.status, seen_result.status);
        check_field("out_job", due_result.out_job, seen_result.out_job);
        check_field("out_user", due_result.out_user, seen_result.out_user);
        check_field("out_program", due_result.out_program, seen_result.out_program);
        check_field("removed_count", due_result.removed_count, seen_result.removed_count);
        check_field("occupancy", due_result.occupancy, seen_result.occupancy);
        responses_checked++;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchdogLimit) begin
      $display("%0t: no transaction for %0d cycles, %0d responses outstanding", $time,
               WatchdogLimit, awaited_results.size());
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The response side decides at the falling edge and drives at the rising edge.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HoldCycles;
      end else if (stall_left == 0 && !steady_flow && $urandom_range(99) < 25) begin
        stall_left = pick_stall();
      end
      @(posedge clk);
      if (stall_left != 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.func = tjq_pkg::FUNC_PUSH;
    req_if.user_id = '0;
    req_if.program_id = '0;
    req_if.cancel_job = '0;
    rst_n = 1'b0;
    steady_flow = 1'b0;
    hold_request = 1'b0;
    mismatch_count = 0;
    responses_checked = 0;
    idle_cycles = 0;
    full_rejects = 0;
    multi_cancels = 0;
    counter_wraps = 0;
    foreach (func_tally[k]) func_tally[k] = 0;
    head_slot = 0;
    held_jobs = 0;
    next_job_nr = tjq_pkg::FirstJob;

    add_row(tjq_pkg::FUNC_POP, 8'h00, 8'h00, 16'h0000, 1'b1,
            {tjq_pkg::STATUS_EMPTY, 16'd0, 8'd0, 8'd0, 5'd0, 5'd0});
    add_row(tjq_pkg::FUNC_CANCEL, 8'h00, 8'h00, 16'hFFFF, 1'b1,
            {tjq_pkg::STATUS_EMPTY, 16'd0, 8'd0, 8'd0, 5'd0, 5'd0});
    add_row(FuncIgnored, 8'hFF, 8'hFF, 16'hFFFF, 1'b1,
            {tjq_pkg::STATUS_OK, 16'd0, 8'd0, 8'd0, 5'd0, 5'd0});
    add_row(tjq_pkg::FUNC_PUSH, 8'h00, 8'h00, 16'h0000, 1'b1,
            {tjq_pkg::STATUS_OK, tjq_pkg::FirstJob, 8'd0, 8'd0, 5'd0, 5'd1});
    add_row(tjq_pkg::FUNC_PUSH, 8'hFF, 8'hFF, 16'hFFFF, 1'b1,
            {tjq_pkg::STATUS_OK, 16'd2, 8'd0, 8'd0, 5'd0, 5'd2});
    add_row(tjq_pkg::FUNC_POP, 8'h00, 8'h00, 16'h0000, 1'b1,
            {tjq_pkg::STATUS_OK, tjq_pkg::FirstJob, 8'h00, 8'h00, 5'd1, 5'd1});
    add_row(tjq_pkg::FUNC_CANCEL, 8'h00, 8'h00, 16'h0000, 1'b1,
            {tjq_pkg::STATUS_NOT_FOUND, 16'd0, 8'd0, 8'd0, 5'd0, 5'd1});
    add_row(tjq_pkg::FUNC_CANCEL, 8'h00, 8'h00, 16'hFFFF, 1'b1,
            {tjq_pkg::STATUS_NOT_FOUND, 16'd0, 8'd0, 8'd0, 5'd0, 5'd1});
    for (int i = 0; i < 15; i++) begin
      add_row(tjq_pkg::FUNC_PUSH, 8'(8'h11 * i), 8'(8'hF0 - i), 16'h0000);
    end
    add_row(tjq_pkg::FUNC_PUSH, 8'h5A, 8'hA5, 16'h0000, 1'b1,
            {tjq_pkg::STATUS_FULL, 16'd0, 8'd0, 8'd0, 5'd0, 5'd16});
    add_row(tjq_pkg::FUNC_CANCEL, 8'h00, 8'h00, 16'd2, 1'b1,
            {tjq_pkg::STATUS_OK, 16'd2, 8'd0, 8'd0, 5'd16, 5'd0});

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      send_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].result);
    end

    // Hold the response side off while pushes keep arriving, so the input stalls.
    steady_flow = 1'b1;
    hold_request = 1'b1;
    for (int i = 0; i < 24; i++) send_request(random_request(100));
    steady_flow = 1'b0;

    random_traffic(320);
    random_traffic(350);

    req_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d push, %0d pop, %0d cancel and %0d unused-code transactions; %0d checked.",
             func_tally[tjq_pkg::FUNC_PUSH], func_tally[tjq_pkg::FUNC_POP],
             func_tally[tjq_pkg::FUNC_CANCEL], func_tally[FuncIgnored], responses_checked);
    $display("Full rejects %0d, cancels removing several jobs %0d, job counter wraps %0d.",
             full_rejects, multi_cancels, counter_wraps);
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/tjq_pkg.sv
hdl/tjq_req_if.sv
hdl/tjq_rsp_if.sv
hdl/tjq_store.sv
hdl/tagged_job_queue_with_flush.sv
dv/tb.sv
